// ----- hdl/phic_pkg.sv -----
// Package for the program image header checker.
// It holds the section and status codes, the layout sizes and the shared structs.
// It has no dependencies.
`default_nettype none

package phic_pkg;

  // Layout of the image header.
  localparam int unsigned NAME_BYTES    = 128;
  localparam int unsigned COMMENT_BYTES = 2048;
  localparam int unsigned WORD_BYTES    = 4;

  // Width of a section length, which may be one more than the largest position.
  localparam int unsigned LEN_W = 17;

  // Reset values of the configuration registers.
  localparam logic [31:0] MAGIC_RESET    = 32'h00EA_83F3;
  localparam logic [15:0] MAX_CODE_RESET = 16'd682;

  // Register indexes on the configuration port.
  localparam logic REG_MAGIC    = 1'b0;
  localparam logic REG_MAX_CODE = 1'b1;

  typedef enum logic [2:0] {
    SEC_MAGIC   = 3'd0,
    SEC_NAME    = 3'd1,
    SEC_PAD1    = 3'd2,
    SEC_SIZE    = 3'd3,
    SEC_COMMENT = 3'd4,
    SEC_PAD2    = 3'd5,
    SEC_CODE    = 3'd6,
    SEC_EXTRA   = 3'd7
  } section_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_HEADER   = 3'd1,
    ST_FORMAT   = 3'd2,
    ST_SIZE     = 3'd3,
    ST_OVERSIZE = 3'd4
  } status_e;

  // Configuration seen by the section walker.
  typedef struct packed {
    logic [31:0] magic_word;
    logic [15:0] max_code_bytes;
  } cfg_t;

  // Progress through one image.
  typedef struct packed {
    section_e    phase;
    logic [15:0] position;
    logic [31:0] word_acc;
    logic [15:0] decoded_size;
    status_e     error_code;
  } walk_state_t;

  // One result item.
  typedef struct packed {
    section_e    section;
    logic [15:0] offset;
    logic [7:0]  data_byte;
    logic [15:0] code_bytes;
    status_e     status;
    logic        image_done;
  } result_t;

  localparam walk_state_t WALK_RESET = '{
    phase:        SEC_MAGIC,
    position:     16'd0,
    word_acc:     32'd0,
    decoded_size: 16'd0,
    error_code:   ST_OK
  };

endpackage

`default_nettype wire

// ----- hdl/phic_regs.sv -----
// Configuration registers of the program image header checker on an APB-style port.
// It depends on phic_pkg for the register indexes and reset values.
`default_nettype none

module phic_regs
  import phic_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  logic [31:0] magic_q;
  logic [15:0] max_code_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register writes; the word index is address bit 2.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q    <= MAGIC_RESET;
      max_code_q <= MAX_CODE_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_MAGIC:    magic_q    <= pwdata;
        REG_MAX_CODE: max_code_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back; the unused address bits are ignored.
  always_comb begin
    case (paddr[2])
      REG_MAGIC:    prdata = magic_q;
      REG_MAX_CODE: prdata = {16'd0, max_code_q};
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg_o = '{magic_word: magic_q, max_code_bytes: max_code_q};

endmodule

`default_nettype wire

// ----- hdl/phic_walk.sv -----
// Section walker: the step of the header check for one byte, as combinational logic.
// It depends on phic_pkg for the state and result structs.
`default_nettype none

module phic_walk
  import phic_pkg::*;
(
  input  wire cfg_t        cfg_i,
  input  wire walk_state_t state_i,
  input  wire logic [7:0]  byte_i,
  input  wire logic        last_i,
  output walk_state_t      state_o,
  output result_t          result_o
);

  section_e           sec;
  logic [31:0]        acc_new;
  logic [LEN_W-1:0]   sec_len;
  logic [LEN_W-1:0]   pos_inc;
  walk_state_t        nxt;
  section_e           phase_new;

  assign sec     = state_i.phase;
  assign acc_new = {state_i.word_acc[23:0], byte_i};
  assign pos_inc = {1'b0, state_i.position} + {{(LEN_W-1){1'b0}}, 1'b1};

  // Length of the current section.
  always_comb begin
    case (sec)
      SEC_NAME:    sec_len = LEN_W'(NAME_BYTES);
      SEC_COMMENT: sec_len = LEN_W'(COMMENT_BYTES);
      SEC_CODE:    sec_len = {1'b0, state_i.decoded_size};
      default:     sec_len = LEN_W'(WORD_BYTES);
    endcase
  end

  // Next state; an error is recorded only while none is held.
  always_comb begin
    nxt       = state_i;
    phase_new = sec;
    if (sec == SEC_EXTRA) begin
      if (nxt.error_code == ST_OK) nxt.error_code = ST_OVERSIZE;
      if (state_i.position != 16'hFFFF) nxt.position = pos_inc[15:0];
    end else if (pos_inc >= sec_len) begin
      // The byte completes its section.
      case (sec)
        SEC_MAGIC: begin
          if (acc_new != cfg_i.magic_word && nxt.error_code == ST_OK)
            nxt.error_code = ST_HEADER;
        end
        SEC_PAD1, SEC_PAD2: begin
          if (acc_new != 32'd0 && nxt.error_code == ST_OK)
            nxt.error_code = ST_FORMAT;
        end
        SEC_SIZE: begin
          if (acc_new[31] || acc_new > {16'd0, cfg_i.max_code_bytes}) begin
            if (nxt.error_code == ST_OK) nxt.error_code = ST_SIZE;
            nxt.decoded_size = 16'd0;
          end else begin
            nxt.decoded_size = acc_new[15:0];
          end
        end
        default: ;
      endcase
      phase_new = section_e'(sec + 3'd1);
      if (phase_new == SEC_CODE && nxt.decoded_size == 16'd0) phase_new = SEC_EXTRA;
      nxt.phase    = phase_new;
      nxt.position = 16'd0;
      nxt.word_acc = 32'd0;
    end else begin
      nxt.position = pos_inc[15:0];
      nxt.word_acc = acc_new;
    end

    // An image that ends before the code is complete is short.
    if (last_i && nxt.error_code == ST_OK) begin
      if (nxt.phase inside {SEC_MAGIC, SEC_PAD1, SEC_SIZE, SEC_PAD2})
        nxt.error_code = ST_HEADER;
      else if (nxt.phase != SEC_EXTRA)
        nxt.error_code = ST_FORMAT;
    end
  end

  // Result of this byte.
  always_comb begin
    result_o.section    = sec;
    result_o.offset     = state_i.position;
    result_o.data_byte  = byte_i;
    result_o.code_bytes = nxt.decoded_size;
    result_o.status     = nxt.error_code;
    result_o.image_done = last_i;
  end

  // The last byte returns the walker to the start of a new image.
  assign state_o = last_i ? WALK_RESET : nxt;

endmodule

`default_nettype wire

// ----- hdl/phic_core.sv -----
// Pipeline of the header checker: input register, walk state and result register.
// It depends on phic_pkg and instantiates phic_walk.
`default_nettype none

module phic_core
  import phic_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output result_t         out_result_o
);

  logic        in_v_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        out_v_q;
  result_t     out_q;
  walk_state_t state_q;
  walk_state_t state_d;
  result_t     result_d;
  logic        advance;
  logic        in_take;

  // A byte moves on when the result register is free or being emptied.
  assign advance    = in_v_q & (~out_v_q | out_ready_i);
  assign in_ready_o = ~in_v_q | advance;
  assign in_take    = in_valid_i & in_ready_o;

  phic_walk u_walk (
    .cfg_i    (cfg_i),
    .state_i  (state_q),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Valid flags and walk state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      state_q <= WALK_RESET;
    end else begin
      if (in_take) in_v_q <= 1'b1;
      else if (advance) in_v_q <= 1'b0;
      if (advance) begin
        out_v_q <= 1'b1;
        state_q <= state_d;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
    if (advance) out_q <= result_d;
  end

  assign out_valid_o  = out_v_q;
  assign out_result_o = out_q;

endmodule

`default_nettype wire

// ----- hdl/program_image_header_checker.sv -----
// Program image header checker: top level with the stream ports and the APB-style port.
// It depends on phic_pkg and instantiates phic_regs and phic_core.
//
// The block takes one image byte per cycle on the slave stream, as long as the master
// stream takes results (tlast marks the last byte of an image), and gives one result per
// byte on the master stream; a byte passes the input register, then the result register.
// The section walk for a byte, one compare and one counter update, is combinational
// between the input register and the result register, and a full result register that is
// being drained does not stall input.
// The result tags the byte with its section (tuser) and offset and carries the decoded code
// size and the first error seen so far; on the last byte, the status is final and the
// checker starts over for the next image. Registers: magic word at byte address 0, largest
// code size at byte address 4; write them only while no image byte is in flight.
`default_nettype none

module program_image_header_checker
  import phic_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input bytes.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  wire logic        s_axis_tlast,   // end_of_image
  // Results.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] offset, [23:16] data_byte, [39:24] code_bytes, [42:40] status, [47:43] zero
  output logic      [47:0] m_axis_tdata,
  output logic      [2:0]  m_axis_tuser,   // [2:0] section
  output logic             m_axis_tlast,   // image_done
  // Configuration.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  cfg_t    cfg;
  result_t res;

  phic_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  phic_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_result_o (res)
  );

  // Pack the result fields onto the master stream.
  assign m_axis_tdata = {5'd0, res.status, res.code_bytes, res.data_byte, res.offset};
  assign m_axis_tuser = res.section;
  assign m_axis_tlast = res.image_done;

endmodule

`default_nettype wire

// ----- bench/phic_result_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the program image header checker testbench.
// It depends on phic_pkg; it predicts each result from the accepted bytes and compares.
`default_nettype none

module phic_result_checker
  import phic_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Byte stream into the block.
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  wire logic        s_axis_tlast,   // end_of_image
  // Result stream out of the block.
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] offset, [23:16] data_byte, [39:24] code_bytes, [42:40] status, [47:43] zero
  input  wire logic [47:0] m_axis_tdata,
  input  wire logic [2:0]  m_axis_tuser,   // [2:0] section
  input  wire logic        m_axis_tlast,   // image_done
  // Configuration port, watched for register writes.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               fail_count_o,
  output int               pending_o
);

  // Shadow copy of the registers and of the walk through one image.
  cfg_t        walk_cfg;
  section_e    walk_phase;
  logic [15:0] walk_pos;
  logic [31:0] walk_word;
  logic [15:0] walk_size;
  status_e     walk_err;

  // Results predicted for accepted bytes, oldest first.
  result_t     predicted_tags[$];

  function automatic void restart_walk();
    walk_phase = SEC_MAGIC;
    walk_pos   = 16'd0;
    walk_word  = 32'd0;
    walk_size  = 16'd0;
    walk_err   = ST_OK;
  endfunction

  // Only the first error of an image is kept.
  function automatic void keep_first_error(input status_e code);
    if (walk_err == ST_OK) begin
      walk_err = code;
    end
  endfunction

  // Advance the walk by one byte and return the result it should give.
  function automatic result_t walk_image_byte(input logic [7:0] b, input logic last);
    result_t     r;
    section_e    sec;
    logic [16:0] sec_len;
    sec         = walk_phase;
    r.section   = sec;
    r.offset    = walk_pos;
    r.data_byte = b;
    if (sec == SEC_EXTRA) begin
      // Bytes after the code: offset saturates at the top of its range.
      keep_first_error(ST_OVERSIZE);
      if (walk_pos != 16'hFFFF) begin
        walk_pos = walk_pos + 16'd1;
      end
    end else begin
      walk_word = {walk_word[23:0], b};
      case (sec)
        SEC_NAME: begin
          sec_len = LEN_W'(NAME_BYTES);
        end
        SEC_COMMENT: begin
          sec_len = LEN_W'(COMMENT_BYTES);
        end
        SEC_CODE: begin
          sec_len = {1'b0, walk_size};
        end
        default: begin
          sec_len = LEN_W'(WORD_BYTES);
        end
      endcase
      if ({1'b0, walk_pos} + 17'd1 >= sec_len) begin
        // The section is complete: check the word it carried.
        if (sec == SEC_MAGIC) begin
          if (walk_word != walk_cfg.magic_word) begin
            keep_first_error(ST_HEADER);
          end
        end else if (sec == SEC_PAD1 || sec == SEC_PAD2) begin
          if (walk_word != 32'd0) begin
            keep_first_error(ST_FORMAT);
          end
        end else if (sec == SEC_SIZE) begin
          if (walk_word[31] || walk_word > {16'd0, walk_cfg.max_code_bytes}) begin
            keep_first_error(ST_SIZE);
            walk_size = 16'd0;
          end else begin
            walk_size = walk_word[15:0];
          end
        end
        walk_phase = section_e'(sec + 3'd1);
        walk_pos   = 16'd0;
        walk_word  = 32'd0;
        if (walk_phase == SEC_CODE && walk_size == 16'd0) begin
          walk_phase = SEC_EXTRA;
        end
      end else begin
        walk_pos = walk_pos + 16'd1;
      end
    end
    // An image that stops early is a header or a format error by where it stopped.
    if (last) begin
      if (walk_phase == SEC_MAGIC || walk_phase == SEC_PAD1 ||
          walk_phase == SEC_SIZE || walk_phase == SEC_PAD2) begin
        keep_first_error(ST_HEADER);
      end else if (walk_phase != SEC_EXTRA) begin
        keep_first_error(ST_FORMAT);
      end
    end
    r.code_bytes = walk_size;
    r.status     = walk_err;
    r.image_done = last;
    if (last) begin
      restart_walk();
    end
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      fail_count_o++;
    end
  endtask

  // Track register writes, predict each accepted byte and check each result.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      walk_cfg.magic_word     = MAGIC_RESET;
      walk_cfg.max_code_bytes = MAX_CODE_RESET;
      restart_walk();
      predicted_tags.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_MAGIC) begin
          walk_cfg.magic_word = pwdata;
        end else begin
          walk_cfg.max_code_bytes = pwdata[15:0];
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_tags.push_back(walk_image_byte(s_axis_tdata, s_axis_tlast));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_tags.size() == 0) begin
          $display("%0t ns: unexpected result transaction, tdata 0x%0h, tuser %0d",
                   $time, m_axis_tdata, m_axis_tuser);
          fail_count_o++;
        end else begin
          want = predicted_tags.pop_front();
          check_field("section", 32'(want.section), 32'(m_axis_tuser));
          check_field("offset", 32'(want.offset), 32'(m_axis_tdata[15:0]));
          check_field("data_byte", 32'(want.data_byte), 32'(m_axis_tdata[23:16]));
          check_field("code_bytes", 32'(want.code_bytes), 32'(m_axis_tdata[39:24]));
          check_field("status", 32'(want.status), 32'(m_axis_tdata[42:40]));
          check_field("image_done", 32'(want.image_done), 32'(m_axis_tlast));
          check_field("tdata padding", 32'd0, 32'(m_axis_tdata[47:43]));
        end
      end
      pending_o = predicted_tags.size();
    end
  end

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the program image header checker testbench: clock, reset, stimulus and verdict.
// It depends on phic_pkg, program_image_header_checker and phic_result_checker.
`default_nettype none

module tb_top
  import phic_pkg::*;
();

  // Byte offset of the code section in a complete image.
  localparam int HDR_BYTES  = 4 * WORD_BYTES + NAME_BYTES + COMMENT_BYTES;
  // Cycles without any transaction before the run is abandoned.
  localparam int QUIET_LIMIT = 4000;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = 3'd0;
  logic [31:0] pwdata        = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending;
  int          quiet_cycles  = 0;
  int          burst_left    = 0;
  logic        long_hold_req = 1'b0;
  logic [31:0] cur_magic     = MAGIC_RESET;
  logic [15:0] cur_max       = MAX_CODE_RESET;
  logic [7:0]  img_bytes[$];

  program_image_header_checker u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  phic_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Clock with a 4 ns period.
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Watchdog: give up after a long stretch with no transaction on any port.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result receiver: stall patterns that change at random, plus one long hold-off on request.
  always begin
    int          hold_left;
    int          mode;
    int          mode_left;
    logic [31:0] pattern;
    hold_left = 0;
    mode_left = 0;
    mode      = 0;
    pattern   = 32'd0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 300);
          pattern   = $urandom;
        end
        mode_left--;
        case (mode)
          0: begin
            m_axis_tready <= 1'b1;
          end
          1: begin
            m_axis_tready <= 1'($urandom_range(0, 1));
          end
          2: begin
            m_axis_tready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            m_axis_tready <= pattern[0];
            pattern = {pattern[0], pattern[31:1]};
          end
        endcase
      end
    end
  end

  // Offer one byte, in bursts separated by random gaps, and wait for its transaction.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 160);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Stop offering bytes and wait until every result has come back.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [31:0] magic, input logic [15:0] max_code);
    wait_idle();
    apb_write({REG_MAGIC, 2'b00}, magic);
    apb_write({REG_MAX_CODE, 2'b00}, {16'd0, max_code});
    cur_magic = magic;
    cur_max   = max_code;
  endtask

  function automatic void push_word(input logic [31:0] w);
    for (int k = 3; k >= 0; k--) begin
      img_bytes.push_back(w[8 * k +: 8]);
    end
  endfunction

  // Send the image held in img_bytes, cut short after cut bytes when cut is nonzero.
  task automatic send_image(input int cut);
    int n;
    n = (cut > 0 && cut < img_bytes.size()) ? cut : img_bytes.size();
    for (int i = 0; i < n; i++) begin
      send_byte(img_bytes[i], i == n - 1);
    end
  endtask

  // Build an image with random name, comment and code bytes, then send it.
  task automatic run_image(input logic [31:0] magic, input logic [31:0] pad1,
                           input logic [31:0] size_word, input logic [31:0] pad2,
                           input int code_n, input int extra_n, input int cut);
    img_bytes.delete();
    push_word(magic);
    repeat (NAME_BYTES) img_bytes.push_back(8'($urandom));
    push_word(pad1);
    push_word(size_word);
    repeat (COMMENT_BYTES) img_bytes.push_back(8'($urandom));
    push_word(pad2);
    repeat (code_n + extra_n) img_bytes.push_back(8'($urandom));
    send_image(cut);
  endtask

  // Built images with one fault at most; the rest short noise.
  task automatic random_image();
    logic [31:0] magic;
    logic [31:0] pad1;
    logic [31:0] pad2;
    logic [31:0] size_word;
    int          code_n;
    int          extra_n;
    int          cut;
    int          lim;
    if ($urandom_range(0, 9) < 3) begin
      img_bytes.delete();
      if ($urandom_range(0, 1) == 1) begin
        push_word(cur_magic);
      end
      repeat ($urandom_range(1, 300)) img_bytes.push_back(8'($urandom));
      send_image(0);
    end else begin
      lim       = (cur_max < 48) ? int'(cur_max) : 48;
      code_n    = $urandom_range(0, lim);
      magic     = cur_magic;
      pad1      = 32'd0;
      pad2      = 32'd0;
      size_word = code_n;
      extra_n   = 0;
      cut       = 0;
      case ($urandom_range(0, 9))
        0: magic     = magic ^ (32'd1 << $urandom_range(0, 31));
        1: pad1      = 32'd1 << $urandom_range(0, 31);
        2: pad2      = 32'd1 << $urandom_range(0, 31);
        3: size_word = $urandom | 32'h8000_0000;
        4: size_word = {16'd0, cur_max} + $urandom_range(1, 2000);
        5: extra_n   = $urandom_range(1, 4);
        6: cut       = $urandom_range(1, HDR_BYTES + code_n);
        default: ;
      endcase
      run_image(magic, pad1, size_word, pad2, code_n, extra_n, cut);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed images with the registers at their reset values.
    run_image(cur_magic, 0, 5, 0, 5, 0, 0);
    run_image(cur_magic, 0, 0, 0, 0, 0, 0);
    run_image(cur_magic, 0, 0, 0, 0, 2, 0);
    run_image(cur_magic ^ 32'h1, 0, 3, 0, 3, 0, 0);
    run_image(cur_magic, 32'h0000_0100, 3, 0, 3, 0, 0);
    run_image(cur_magic, 0, 3, 32'h8000_0000, 3, 0, 0);
    run_image(cur_magic, 0, 32'hFFFF_FFFF, 0, 0, 1, 0);
    run_image(cur_magic, 0, 683, 0, 0, 0, 0);
    run_image(cur_magic, 0, 682, 0, 682, 0, 0);
    // Several faults in one image: the bad magic must win.
    run_image(cur_magic ^ 32'h8000_0000, 32'hFF, 4, 32'hFF, 4, 3, 0);
    // Images that stop inside or just ahead of each kind of section.
    run_image(cur_magic, 0, 5, 0, 5, 0, 1);
    run_image(cur_magic, 0, 5, 0, 5, 0, 4);
    run_image(cur_magic, 0, 5, 0, 5, 0, 4 + NAME_BYTES);
    run_image(cur_magic, 0, 5, 0, 5, 0, 10 + NAME_BYTES);
    run_image(cur_magic, 0, 5, 0, 5, 0, 12 + NAME_BYTES + 100);
    run_image(cur_magic, 0, 5, 0, 5, 0, HDR_BYTES);
    run_image(cur_magic, 0, 5, 0, 5, 0, HDR_BYTES + 2);

    // Lowest register values.
    set_config(32'd0, 16'd0);
    run_image(32'd0, 0, 0, 0, 0, 0, 0);
    run_image(32'd0, 0, 1, 0, 1, 0, 0);
    run_image(MAGIC_RESET, 0, 0, 0, 0, 0, 0);

    // Highest register values, and an extra section long enough to saturate its offset.
    set_config(32'hFFFF_FFFF, 16'hFFFF);
    run_image(cur_magic, 0, 32'h0000_FFFF, 0, 10, 0, 0);
    run_image(cur_magic, 0, 32'h0001_0000, 0, 0, 0, 0);
    run_image(cur_magic, 0, 32'h7FFF_FFFF, 0, 0, 0, 0);
    run_image(cur_magic, 0, 0, 0, 0, 65538, 0);

    // Random images under several register settings.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_config($urandom, 16'($urandom_range(0, 64)));
        1: set_config($urandom, 16'($urandom_range(32, 300)));
        2: set_config($urandom, 16'hFFFF);
        default: set_config($urandom, 16'($urandom_range(0, 16)));
      endcase
      for (int k = 0; k < 9; k++) begin
        if (ph == 1 && k == 2) begin
          long_hold_req = 1'b1;
        end
        if (ph == 2 && k == 4) begin
          wait_idle();
        end
        random_image();
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
